@@ hw/rtl/tccs_pkg.sv @@
`default_nettype none

package tccs_pkg;

    // fixed widths of the transaction fields
    localparam int REQ_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CELL_W      = 16;
    localparam int CUR_ROW_W   = 6;
    localparam int CUR_COL_W   = 7;

    // internal cursor widths, sized for the largest supported screen
    // (row up to 2*128-1, column up to 256)
    localparam int ROW_W       = 8;
    localparam int COL_W       = 9;

    // widest cell address for the largest supported screen (256 x 128)
    localparam int ADDR_MAX_W  = 15;

    // cell encoding
    localparam logic [7:0]        ATTR_WHITE   = 8'h0F;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    // request codes on the input channel
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // work codes handed from the front to the back
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd_op;

    // one classified request, with the cursor it leaves behind
    typedef struct packed {
        t_cmd_op                op;
        logic                   scroll;
        logic                   copy;
        logic [ADDR_MAX_W-1:0]  src_start;
        logic [ADDR_MAX_W-1:0]  blank_start;
        logic [ADDR_MAX_W-1:0]  wr_addr;
        logic [CHAR_W-1:0]      wr_char;
        logic [ADDR_MAX_W-1:0]  rd_addr;
        logic                   rd_ok;
        logic [CUR_ROW_W-1:0]   row;
        logic [CUR_COL_W-1:0]   col;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
    } t_result;

    // status from the back to the front
    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

`default_nettype wire

@@ hw/rtl/tccs_if.sv @@
`default_nettype none

// request channel
interface tccs_in_if;
    logic                          valid;
    logic                          ready;
    logic [tccs_pkg::REQ_W-1:0]    req_type;
    logic [tccs_pkg::CHAR_W-1:0]   char_code;
    logic [tccs_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output req_type, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input req_type, input char_code, input cell_index,
                    output ready);
endinterface

// result channel
interface tccs_out_if;
    logic                            valid;
    logic                            ready;
    logic [tccs_pkg::CELL_W-1:0]     cell_data;
    logic [tccs_pkg::CUR_ROW_W-1:0]  cursor_row;
    logic [tccs_pkg::CUR_COL_W-1:0]  cursor_col;

    modport source (output valid, output cell_data, output cursor_row, output cursor_col,
                    input ready);
    modport sink   (input valid, input cell_data, input cursor_row, input cursor_col,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/text_console_cursor_scroll.sv @@
`default_nettype none

// Text-mode console writer over a ROWS x COLUMNS store of 16-bit cells
// (attribute 0x0F in the high byte, character in the low byte). Each request
// transaction (put character, clear, read cell) returns exactly one result
// transaction carrying the cell read (zero for other requests) and the cursor
// after the request. The front tracks the cursor and classifies requests into
// a two-entry queue; the back carries out the store work on a single-port-write
// RAM with registered read, and that write port sets the pace: a plain
// character or a read passes through a second state (S_PUT or S_READ), a
// newline or unknown request is finished in S_IDLE, a clear blanks every
// cell, and a put that scrolls k lines copies any kept lines, writes the last
// copied cell, blanks the vacated lines, then writes. After reset a clearing
// pass blanks the store, during which no request is accepted. The front
// accepts a request every cycle while the queue has room, and a waiting result does not block it.
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tccs_in_if.sink    i_in,
    tccs_out_if.source o_out
);

    logic                  w_q_ready;
    logic                  w_q_push;
    tccs_pkg::t_cmd        w_q_wdata;
    logic                  w_q_valid;
    logic                  w_q_pop;
    tccs_pkg::t_cmd        w_q_rdata;
    tccs_pkg::t_back_status w_status;

    // cursor tracking and request classification
    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_status  (w_status),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_q_push),
        .o_q_data  (w_q_wdata)
    );

    // command queue between front and back
    tccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    // screen store sequencer and result register
    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_status  (w_status),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tccs_ram.sv @@
`default_nettype none

module tccs_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 2000,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/tccs_front.sv @@
`default_nettype none

module tccs_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tccs_in_if.sink                    i_in,
    input  wire tccs_pkg::t_back_status i_status,
    input  wire logic                  i_q_ready,
    output logic                       o_q_push,
    output tccs_pkg::t_cmd             o_q_data
);

    localparam int ROW_W      = tccs_pkg::ROW_W;
    localparam int COL_W      = tccs_pkg::COL_W;
    localparam int AMW        = tccs_pkg::ADDR_MAX_W;
    localparam int PROD_W     = AMW + 2;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam logic [ROW_W-1:0]  ROWS_C      = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LIMIT_C = ROW_W'(2 * ROWS - 1);
    localparam logic [COL_W-1:0]  COLS_C      = COL_W'(COLUMNS);
    localparam logic [PROD_W-1:0] CELLS_C     = PROD_W'(CELL_COUNT);

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;

    logic              w_accept;
    logic [ROW_W-1:0]  w_row_inc;
    logic              w_wrap;
    logic [ROW_W-1:0]  w_row_a;
    logic [COL_W-1:0]  w_col_a;
    logic              w_scroll;
    logic [ROW_W-1:0]  w_lines;
    logic [ROW_W-1:0]  w_put_row;
    logic [COL_W-1:0]  w_put_col;
    logic [PROD_W-1:0] w_wr_pos;
    logic [PROD_W-1:0] w_shift;
    logic [PROD_W-1:0] w_keep;
    logic              w_copy;
    logic              w_rd_ok;
    tccs_pkg::t_cmd    w_cmd;

    // hold off new requests while the store is swept after reset
    assign i_in.ready = i_q_ready && !i_status.init_busy;
    assign w_accept   = i_in.valid && i_in.ready;

    // next row, saturating where enough scrolls blank the whole screen
    assign w_row_inc = (r_row < ROW_LIMIT_C) ? r_row + 1'b1 : r_row;

    // wrap at the right edge, then fold excess rows into a scroll
    assign w_wrap    = (r_col >= COLS_C);
    assign w_row_a   = w_wrap ? w_row_inc : r_row;
    assign w_col_a   = w_wrap ? '0 : r_col;
    assign w_scroll  = (w_row_a >= ROWS_C);
    assign w_lines   = w_scroll ? (w_row_a - ROWS_C + 1'b1) : '0;
    assign w_put_row = w_scroll ? (ROWS_C - 1'b1) : w_row_a;
    assign w_put_col = w_scroll ? '0 : w_col_a;
    assign w_copy    = w_scroll && (w_lines < ROWS_C);

    // cell address of the write and the span moved by the scroll
    assign w_wr_pos = PROD_W'(w_put_row) * PROD_W'(COLUMNS) + PROD_W'(w_put_col);
    assign w_shift  = PROD_W'(w_lines) * PROD_W'(COLUMNS);
    assign w_keep   = CELLS_C - w_shift;

    // read range check
    assign w_rd_ok = (PROD_W'(i_in.cell_index) < CELLS_C);

    // classify the request and work out the cursor it leaves
    always_comb begin
        n_row             = r_row;
        n_col             = r_col;
        w_cmd.op          = tccs_pkg::CMD_NONE;
        w_cmd.scroll      = 1'b0;
        w_cmd.copy        = 1'b0;
        w_cmd.src_start   = AMW'(w_shift);
        w_cmd.blank_start = w_copy ? AMW'(w_keep) : '0;
        w_cmd.wr_addr     = AMW'(w_wr_pos);
        w_cmd.wr_char     = i_in.char_code;
        w_cmd.rd_addr     = AMW'(i_in.cell_index);
        w_cmd.rd_ok       = w_rd_ok;
        unique case (tccs_pkg::t_req'(i_in.req_type))
            tccs_pkg::REQ_PUT: begin
                if (i_in.char_code == tccs_pkg::NEWLINE_CODE) begin
                    n_row = w_row_inc;
                    n_col = '0;
                end else begin
                    w_cmd.op     = tccs_pkg::CMD_PUT;
                    w_cmd.scroll = w_scroll;
                    w_cmd.copy   = w_copy;
                    n_row        = w_put_row;
                    n_col        = w_put_col + 1'b1;
                end
            end
            tccs_pkg::REQ_CLEAR: begin
                w_cmd.op = tccs_pkg::CMD_CLEAR;
                n_row    = '0;
                n_col    = '0;
            end
            tccs_pkg::REQ_READ: begin
                w_cmd.op = tccs_pkg::CMD_READ;
            end
            tccs_pkg::REQ_NONE: begin
                w_cmd.op = tccs_pkg::CMD_NONE;
            end
            default: begin
                w_cmd.op = tccs_pkg::CMD_NONE;
            end
        endcase
        w_cmd.row = n_row[tccs_pkg::CUR_ROW_W-1:0];
        w_cmd.col = n_col[tccs_pkg::CUR_COL_W-1:0];
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_q_push = w_accept;
    assign o_q_data = w_cmd;

endmodule

`default_nettype wire

@@ hw/rtl/tccs_queue.sv @@
`default_nettype none

module tccs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tccs_pkg::t_cmd i_data,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tccs_pkg::t_cmd      o_data
);

    tccs_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tccs_back.sv @@
`default_nettype none

module tccs_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire tccs_pkg::t_cmd   i_q_data,
    output logic                  o_q_pop,
    output tccs_pkg::t_back_status o_status,
    tccs_out_if.source            o_out
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_C = ADDR_W'(CELL_COUNT - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_COPY  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_BLANK = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_READ  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic                r_cp_wv, n_cp_wv;
    logic [ADDR_W-1:0]   r_cp_wa, n_cp_wa;
    tccs_pkg::t_cmd      r_cmd, n_cmd;
    logic                r_out_valid;
    tccs_pkg::t_result   r_out;

    logic                        w_slot_free;
    logic                        w_pop;
    logic                        w_load;
    tccs_pkg::t_result           w_res;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [tccs_pkg::CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0]           w_raddr;
    logic [tccs_pkg::CELL_W-1:0] w_rdata;

    // screen store
    tccs_ram #(
        .WIDTH (tccs_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // a new command starts only when its result has a free slot
    assign w_slot_free = !r_out_valid || o_out.ready;

    // sequencer over the store
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_cp_wv = r_cp_wv;
        n_cp_wa = r_cp_wa;
        n_cmd   = r_cmd;
        w_pop   = 1'b0;
        w_load  = 1'b0;
        w_res.cell_data  = '0;
        w_res.cursor_row = r_cmd.row;
        w_res.cursor_col = r_cmd.col;
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = tccs_pkg::BLANK_CELL;
        w_raddr = r_ptr;
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;
                if (r_ptr == LAST_C) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                w_raddr = i_q_data.rd_addr[ADDR_W-1:0];
                if (i_q_valid && w_slot_free) begin
                    w_pop = 1'b1;
                    n_cmd = i_q_data;
                    unique case (i_q_data.op)
                        tccs_pkg::CMD_NONE: begin
                            w_load           = 1'b1;
                            w_res.cursor_row = i_q_data.row;
                            w_res.cursor_col = i_q_data.col;
                        end
                        tccs_pkg::CMD_PUT: begin
                            if (i_q_data.copy) begin
                                n_state = S_COPY;
                                n_ptr   = i_q_data.src_start[ADDR_W-1:0];
                                n_cp_wv = 1'b0;
                            end else if (i_q_data.scroll) begin
                                n_state = S_BLANK;
                                n_ptr   = i_q_data.blank_start[ADDR_W-1:0];
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        tccs_pkg::CMD_CLEAR: begin
                            n_state = S_BLANK;
                            n_ptr   = '0;
                        end
                        tccs_pkg::CMD_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                // read ahead at the source, write the previous cell at its scrolled-up place
                w_we    = r_cp_wv;
                w_waddr = r_cp_wa;
                w_wdata = w_rdata;
                n_cp_wv = 1'b1;
                n_cp_wa = r_ptr - r_cmd.src_start[ADDR_W-1:0];
                if (r_ptr == LAST_C) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DRAIN: begin
                w_we    = 1'b1;
                w_waddr = r_cp_wa;
                w_wdata = w_rdata;
                n_cp_wv = 1'b0;
                n_state = S_BLANK;
                n_ptr   = r_cmd.blank_start[ADDR_W-1:0];
            end
            S_BLANK: begin
                w_we = 1'b1;
                if (r_ptr == LAST_C) begin
                    if (r_cmd.op == tccs_pkg::CMD_CLEAR) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_cmd.wr_addr[ADDR_W-1:0];
                w_wdata = {tccs_pkg::ATTR_WHITE, r_cmd.wr_char};
                w_load  = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                w_res.cell_data = r_cmd.rd_ok ? w_rdata : '0;
                w_load          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_cp_wv     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cp_wv <= n_cp_wv;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cp_wa <= n_cp_wa;
        r_cmd   <= n_cmd;
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_q_pop            = w_pop;
    assign o_status.init_busy = (r_state == S_INIT);

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_data  = r_out.cell_data;
    assign o_out.cursor_row = r_out.cursor_row;
    assign o_out.cursor_col = r_out.cursor_col;

endmodule

`default_nettype wire
